// File: src/lfu_cache_replacement_macros.svh
// assertion macros shared by the checker of the lfu cache
// no dependencies; included by bare file name
`ifndef LFU_CACHE_REPLACEMENT_MACROS_SVH
`define LFU_CACHE_REPLACEMENT_MACROS_SVH

// same-cycle implication under clock and active-low reset
`define LFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under clock and active-low reset
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lfu_pkg.sv
// types and constants of the lfu cache with lru tie break
// no dependencies; imported by lfu_scan, lfu_cache_replacement and lfu_checker
package lfu_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int USE_W = 32;
	localparam int STAMP_W = 48;
	localparam int CAP_W = 5;
	localparam int CAP_RESET = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index as seen on paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [USE_W-1:0]   count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic [VAL_W-1:0]   hit_value;
		logic [USE_W-1:0]   hit_count;
		logic               free;
		logic [IDX_W-1:0]   free_idx;
		logic               vic;
		logic [IDX_W-1:0]   vic_idx;
		logic [KEY_W-1:0]   vic_key;
		logic [CNT_W-1:0]   used;
	} scan_res_t;

endpackage

// File: src/lfu_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lfu_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/lfu_scan.sv
// scan unit: walks the slots one per cycle and keeps key match, free slot,
// eviction candidate and occupancy; uses lfu_pkg
module lfu_scan import lfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             vld,
	input  logic [IDX_W-1:0] slot,
	input  logic             slot_valid,
	input  entry_t           rd,
	input  logic [KEY_W-1:0] key,
	output scan_res_t        res
);

	logic             hit_q, free_q, vic_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, vic_idx_q;
	logic [VAL_W-1:0] hit_value_q;
	logic [USE_W-1:0] hit_count_q, vic_count_q;
	logic [STAMP_W-1:0] vic_stamp_q;
	logic [KEY_W-1:0] vic_key_q;
	logic [CNT_W-1:0] used_q;
	logic             better;

	// smaller count wins, then older stamp; equal keeps the lower slot
	assign better = !vic_q || (rd.count < vic_count_q) ||
		((rd.count == vic_count_q) && (rd.stamp < vic_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			vic_q  <= 1'b0;
			used_q <= '0;
		end else if (clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			vic_q  <= 1'b0;
			used_q <= '0;
		end else if (vld) begin
			if (!slot_valid) begin
				if (!free_q) begin
					free_q <= 1'b1;
				end
			end else begin
				used_q <= used_q + CNT_W'(1);
				if (!hit_q && (rd.key == key)) begin
					hit_q <= 1'b1;
				end
				if (better) begin
					vic_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld) begin
			if (!slot_valid) begin
				if (!free_q) begin
					free_idx_q <= slot;
				end
			end else begin
				if (!hit_q && (rd.key == key)) begin
					hit_idx_q   <= slot;
					hit_value_q <= rd.value;
					hit_count_q <= rd.count;
				end
				if (better) begin
					vic_idx_q   <= slot;
					vic_count_q <= rd.count;
					vic_stamp_q <= rd.stamp;
					vic_key_q   <= rd.key;
				end
			end
		end
	end

	always_comb begin
		res.hit       = hit_q;
		res.hit_idx   = hit_idx_q;
		res.hit_value = hit_value_q;
		res.hit_count = hit_count_q;
		res.free      = free_q;
		res.free_idx  = free_idx_q;
		res.vic       = vic_q;
		res.vic_idx   = vic_idx_q;
		res.vic_key   = vic_key_q;
		res.used      = used_q;
	end

endmodule

// File: src/lfu_cache_replacement.sv
// top level of the lfu key-value cache with lru tie break
// uses lfu_pkg, lfu_ram and lfu_scan
//
//  channel  | handshake                       | word
//  ---------+---------------------------------+--------------------------------------
//  command  | start && !busy                  | op, key, value
//  result   | done, one cycle, no backpressure | found, read_value, evicted, evicted_key
//  config   | apb write, psel&penable&pwrite  | capacity_in_use at byte address 0
//
// each access reads one slot of the entry ram per cycle in ST_SCAN, then passes ST_LAST
// (drain) and ST_WRITE (write-back) before the result strobe. a new command is
// taken in the cycle the result is shown; busy holds off commands until then.
// reset clears valid bits, op clock and capacity (to 16) at once; no clearing pass.
// results cannot be stalled.
module lfu_cache_replacement import lfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [KEY_W-1:0]   key,
	input  logic [VAL_W-1:0]   value,
	output logic               done,
	output logic               found,
	output logic [VAL_W-1:0]   read_value,
	output logic               evicted,
	output logic [KEY_W-1:0]   evicted_key,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_LAST  = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	state_t              state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [ENTRIES-1:0]  valid_q;
	logic [STAMP_W-1:0]  clock_q;
	logic [CAP_W-1:0]    cap_q;
	logic                op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    value_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    slot_s1;
	logic                slot_valid_s1;
	logic                done_q, found_q, evicted_q;
	logic [VAL_W-1:0]    read_value_q;
	logic [KEY_W-1:0]    evicted_key_q;

	logic                accept;
	logic                cfg_wr;
	entry_t              rd_data;
	entry_t              wr_data;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	scan_res_t           scan;
	logic [CMP_W-1:0]    cap_x, cap_eff, used_x;
	logic                cap_on, do_evict, do_store;
	logic [STAMP_W-1:0]  clock_nxt;
	logic [USE_W-1:0]    count_inc;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RESET);
		end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// capacity above the slot count acts as the slot count
	always_comb begin
		cap_x   = CMP_W'(cap_q);
		used_x  = CMP_W'(scan.used);
		cap_eff = (cap_x > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_x;
		cap_on  = (cap_eff != '0);
	end

	assign clock_nxt = clock_q + STAMP_W'(1);
	assign count_inc = (scan.hit_count == '1) ? scan.hit_count : scan.hit_count + USE_W'(1);

	always_comb begin
		do_evict = 1'b0;
		do_store = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = scan.free_idx;
		wr_data.key   = key_q;
		wr_data.value = value_q;
		wr_data.count = USE_W'(1);
		wr_data.stamp = clock_nxt;
		if (state_q == ST_WRITE && cap_on) begin
			if (scan.hit) begin
				wr_en  = 1'b1;
				wr_idx = scan.hit_idx;
				wr_data.value = (op_q == OP_PUT) ? value_q : scan.hit_value;
				wr_data.count = count_inc;
			end else if (op_q == OP_PUT) begin
				do_evict = (used_x >= cap_eff) && scan.vic;
				do_store = do_evict || scan.free;
				wr_en    = do_store;
				wr_idx   = do_evict ? scan.vic_idx : scan.free_idx;
			end
		end
	end

	lfu_ram #(
		.DEPTH(ENTRIES),
		.WIDTH($bits(entry_t))
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_data),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	lfu_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.vld        (rd_vld_s1),
		.slot       (slot_s1),
		.slot_valid (slot_valid_s1),
		.rd         (rd_data),
		.key        (key_q),
		.res        (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			valid_q   <= '0;
			clock_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			done_q    <= (state_q == ST_WRITE);
			if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
				clock_q         <= clock_nxt;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			key_q   <= key;
			value_q <= value;
		end
		slot_s1       <= idx_q;
		slot_valid_s1 <= valid_q[idx_q];
		if (state_q == ST_WRITE) begin
			found_q       <= cap_on && scan.hit;
			read_value_q  <= (cap_on && scan.hit && (op_q == OP_GET)) ? scan.hit_value : '0;
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? scan.vic_key : '0;
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule

// File: src/lfu_checker.sv
// port-level checker for the lfu cache, bound to the top level
// uses lfu_pkg and lfu_cache_replacement_macros.svh
`include "lfu_cache_replacement_macros.svh"

module lfu_checker import lfu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               found,
	input logic [VAL_W-1:0]   read_value,
	input logic               evicted,
	input logic [KEY_W-1:0]   evicted_key
);

	// an accepted word keeps the block busy
	`LFU_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")

	// the result strobe lasts exactly one cycle
	`LFU_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held over two cycles")

	// a present key is never evicted on the same access
	`LFU_ASSERT_NOW(a_hit_no_evict, clk, arst_n, done && found, !evicted, "hit reported an eviction")

	// read data is zero unless the key was found
	`LFU_ASSERT_NOW(a_miss_zero, clk, arst_n, done && !found, read_value == '0, "miss returned data")

	// no evicted key without an eviction
	`LFU_ASSERT_NOW(a_evk_zero, clk, arst_n, done && !evicted, evicted_key == '0, "stray evicted key")

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (.*);
